// ===== rtl/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants of the conversion sequencer
// Operation, status and job codes, configuration register indexes and the
// result record that travels through the output stage.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int unsigned CHANNEL_COUNT = 8;
    localparam int unsigned MAX_CHAIN     = 8;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned CH_IN_W  = 4;
    localparam int unsigned CH_W     = 3;
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned LIST_W   = 24;
    localparam int unsigned WAIT_W   = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CH_IN_W-1:0] LAST_CHANNEL = CH_IN_W'(CHANNEL_COUNT - 1);
    localparam logic [LEN_W-1:0]   CHAIN_MAX    = LEN_W'(MAX_CHAIN);
    localparam logic [WAIT_W-1:0]  TIMEOUT_RESET = WAIT_W'(50000);

    // Input operation codes
    localparam logic [OP_W-1:0] OP_POLLED = 3'd0;
    localparam logic [OP_W-1:0] OP_SINGLE = 3'd1;
    localparam logic [OP_W-1:0] OP_CHAIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_DONE   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd3;

    typedef enum logic [1:0] {
        JOB_NONE   = 2'd0,
        JOB_POLLED = 2'd1,
        JOB_SINGLE = 2'd2,
        JOB_CHAIN  = 2'd3
    } t_job_kind;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                start_conversion;
        logic [CH_W-1:0]     conversion_channel;
        logic                reading_valid;
        logic [SAMPLE_W-1:0] reading;
        logic [IDX_W-1:0]    reading_index;
        logic                job_done;
    } t_result;

endpackage

// ===== rtl/adc_conversion_sequencer.sv =====
// Each result is registered in the output register, or in the skid register.
// Throughput: one input transfer per cycle while the input is not stalled;
// the output and skid registers let a new item in while a result waits.
// Input stall rises only when the skid register holds a result.
// Reset (synchronous, active low): idle, no job, config at 0, 1, 0, 50000.
// ----------------------------------------------------------------------------
// adc_conversion_sequencer: start/chain/timeout sequencer for an 8-channel ADC
// Decodes start, conversion-done and tick events, tracks the running job,
// issues conversion requests and passes readings through in 10 or 8 bits.
// ----------------------------------------------------------------------------
module adc_conversion_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // event input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [acs_pkg::OP_W-1:0]           i_operation,
    input  logic [acs_pkg::CH_IN_W-1:0]        i_channel,
    input  logic [acs_pkg::SAMPLE_W-1:0]       i_sample,
    // result output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [acs_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_start_conversion,
    output logic [acs_pkg::CH_W-1:0]           o_conversion_channel,
    output logic                               o_reading_valid,
    output logic [acs_pkg::SAMPLE_W-1:0]       o_reading,
    output logic [acs_pkg::IDX_W-1:0]          o_reading_index,
    output logic                               o_job_done
);
    import acs_pkg::*;

    // Configuration registers
    logic                r_eight_bit;
    logic [LEN_W-1:0]    r_chain_len;
    logic [LIST_W-1:0]   r_chain_list;
    logic [WAIT_W-1:0]   r_timeout;

    // Job state
    logic                r_busy,     n_busy;
    t_job_kind           r_job,      n_job;
    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [WAIT_W-1:0]   r_wait,     n_wait;

    // Output register and skid register
    t_result             r_out,      r_skid;
    logic                r_out_valid, r_skid_valid;
    t_result             n_result;

    logic                in_xfer;
    logic                out_xfer;
    logic [LEN_W-1:0]    eff_len;
    logic [POS_W-1:0]    next_pos;
    logic [WAIT_W-1:0]   wait_inc;
    logic [SAMPLE_W-1:0] scaled;
    logic [CH_W-1:0]     list_ch;
    logic [IDX_W-1:0]    list_idx;

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // Configuration writes: the user writes only while idle; not guarded here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight_bit  <= 1'b0;
            r_chain_len  <= LEN_W'(1);
            r_chain_list <= '0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EIGHT_BIT: r_eight_bit  <= i_cfg_data[0];
                CFG_CHAIN_LEN: r_chain_len  <= i_cfg_data[LEN_W-1:0];
                CFG_CHAIN_LST: r_chain_list <= i_cfg_data[LIST_W-1:0];
                CFG_TIMEOUT:   r_timeout    <= i_cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the chain length into 1..MAX_CHAIN.
    always_comb begin
        if (r_chain_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_chain_len > CHAIN_MAX) begin
            eff_len = CHAIN_MAX;
        end else begin
            eff_len = r_chain_len;
        end
    end

    assign next_pos = r_pos + POS_W'(1);
    assign wait_inc = r_wait + WAIT_W'(1);
    assign scaled   = r_eight_bit ? {2'b00, i_sample[SAMPLE_W-1:2]} : i_sample;

    // A chain start reads entry zero, an advancing chain the next entry.
    // next_pos stays below the clamped length there, so its low bits suffice.
    assign list_idx = (i_operation == OP_CHAIN) ? '0 : next_pos[IDX_W-1:0];
    assign list_ch  = r_chain_list[CH_W*list_idx +: CH_W];

    // Event decode: next job state and the result record.
    always_comb begin
        n_busy   = r_busy;
        n_job    = r_job;
        n_pos    = r_pos;
        n_wait   = r_wait;
        n_result = '0;
        unique case (i_operation) inside
            OP_POLLED, OP_SINGLE, OP_CHAIN: begin
                if (r_busy) begin
                    n_result.status = ST_BUSY;
                end else if (i_operation == OP_CHAIN) begin
                    n_busy = 1'b1;
                    n_job  = JOB_CHAIN;
                    n_pos  = '0;
                    n_wait = '0;
                    n_result.start_conversion   = 1'b1;
                    n_result.conversion_channel = list_ch;
                end else if (i_channel > LAST_CHANNEL) begin
                    n_result.status = ST_RANGE;
                end else begin
                    n_busy = 1'b1;
                    n_job  = (i_operation == OP_POLLED) ? JOB_POLLED : JOB_SINGLE;
                    n_pos  = '0;
                    n_wait = '0;
                    n_result.start_conversion   = 1'b1;
                    n_result.conversion_channel = i_channel[CH_W-1:0];
                end
            end
            OP_DONE: begin
                if (r_job == JOB_POLLED || r_job == JOB_SINGLE) begin
                    n_result.reading_valid = 1'b1;
                    n_result.reading       = scaled;
                    n_result.job_done      = 1'b1;
                    n_busy = 1'b0;
                    n_job  = JOB_NONE;
                    n_pos  = '0;
                    n_wait = '0;
                end else if (r_job == JOB_CHAIN) begin
                    n_result.reading_valid = 1'b1;
                    n_result.reading       = scaled;
                    n_result.reading_index = r_pos[IDX_W-1:0];
                    if (next_pos >= eff_len) begin
                        // last channel of the list: finish the job
                        n_result.job_done = 1'b1;
                        n_busy = 1'b0;
                        n_job  = JOB_NONE;
                        n_pos  = '0;
                        n_wait = '0;
                    end else begin
                        // advance to the next listed channel
                        n_pos = next_pos;
                        n_result.start_conversion   = 1'b1;
                        n_result.conversion_channel = list_ch;
                    end
                end
            end
            OP_TICK: begin
                if (r_job == JOB_POLLED) begin
                    n_wait = wait_inc;
                    if (wait_inc >= r_timeout) begin
                        n_result.status = ST_TIMEOUT;
                        n_busy = 1'b0;
                        n_job  = JOB_NONE;
                        n_pos  = '0;
                        n_wait = '0;
                    end
                end
            end
            default: ;  // unused codes: no change, status ok
        endcase
    end

    // Job state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_job  <= JOB_NONE;
            r_pos  <= '0;
            r_wait <= '0;
        end else if (in_xfer) begin
            r_busy <= n_busy;
            r_job  <= n_job;
            r_pos  <= n_pos;
            r_wait <= n_wait;
        end
    end

    // Output stage: load the output register when it is free or draining,
    // park the result in the skid register when the output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer && r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_xfer && (out_xfer || !r_out_valid)) begin
            r_out <= n_result;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out.status;
    assign o_start_conversion   = r_out.start_conversion;
    assign o_conversion_channel = r_out.conversion_channel;
    assign o_reading_valid      = r_out.reading_valid;
    assign o_reading            = r_out.reading;
    assign o_reading_index      = r_out.reading_index;
    assign o_job_done           = r_out.job_done;

    // The skid register only fills behind a held output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid without output register");

    // Busy flag and job kind agree.
    a_busy_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_job != JOB_NONE))
        else $error("busy flag and job kind disagree");

    // Chain position moves only within a chain job and stays inside the list.
    a_pos_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (r_job == JOB_CHAIN && r_pos < POS_W'(MAX_CHAIN)))
        else $error("chain position outside a chain job");

    // The wait counter runs only in a polled job.
    a_wait_polled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != '0) |-> (r_job == JOB_POLLED))
        else $error("wait counter outside a polled job");

    // Every input transfer leaves a result behind.
    a_xfer_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("input transfer produced no result");

endmodule
